// ----- design/iml_pkg.sv -----
`timescale 1ns / 1ps

package iml_pkg;

    localparam int ROWS_DEF = 64;
    localparam int COLS_DEF = 64;

    localparam int SITE_W = 12;
    localparam int RND_W  = 32;
    localparam int MAG_W  = 14;
    localparam int ENG_W  = 15;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register select is paddr bit 2
    localparam logic REG_THR_FOUR  = 1'b0;
    localparam logic REG_THR_EIGHT = 1'b1;

    localparam logic [RND_W-1:0] THR_FOUR_RST  = 32'd737360000;
    localparam logic [RND_W-1:0] THR_EIGHT_RST = 32'd126590000;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_UPDATE = 1'b1;

    // site / COLS by reciprocal multiply
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 23;

    typedef struct packed {
        logic [RND_W-1:0] four;
        logic [RND_W-1:0] eight;
    } t_thresholds;

endpackage

// ----- design/iml_cfg_regs.sv -----
`timescale 1ns / 1ps

module iml_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [iml_pkg::APB_AW-1:0]     paddr,
    input  logic [iml_pkg::APB_DW-1:0]     pwdata,
    output logic [iml_pkg::APB_DW-1:0]     prdata,
    output logic                           pready,
    output iml_pkg::t_thresholds           o_thr
);

    iml_pkg::t_thresholds r_thr;
    logic                 wr_xfer;

    assign pready  = 1'b1;
    assign wr_xfer = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.four  <= iml_pkg::THR_FOUR_RST;
            r_thr.eight <= iml_pkg::THR_EIGHT_RST;
        end else if (wr_xfer) begin
            unique case (paddr[2])
                iml_pkg::REG_THR_FOUR:  r_thr.four  <= pwdata;
                iml_pkg::REG_THR_EIGHT: r_thr.eight <= pwdata;
                default:                r_thr.four  <= r_thr.four;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            iml_pkg::REG_THR_FOUR:  prdata = r_thr.four;
            iml_pkg::REG_THR_EIGHT: prdata = r_thr.eight;
            default:                prdata = '0;
        endcase
    end

    assign o_thr = r_thr;

endmodule

// ----- design/iml_lattice_ram.sv -----
`timescale 1ns / 1ps

module iml_lattice_ram #(
    parameter int ROWS = iml_pkg::ROWS_DEF,
    parameter int COLS = iml_pkg::COLS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(ROWS)-1:0]  i_waddr,
    input  logic [COLS-1:0]          i_wdata,
    input  logic                     i_re_a,
    input  logic [$clog2(ROWS)-1:0]  i_raddr_a,
    input  logic                     i_re_b,
    input  logic [$clog2(ROWS)-1:0]  i_raddr_b,
    output logic [COLS-1:0]          o_rdata_a,
    output logic [COLS-1:0]          o_rdata_b
);

    logic [COLS-1:0] mem [ROWS];
    logic [COLS-1:0] r_q_a;
    logic [COLS-1:0] r_q_b;
    logic [COLS-1:0] r_fwd_a;
    logic [COLS-1:0] r_fwd_b;
    logic            r_hit_a;
    logic            r_hit_b;
    logic            hit_a;
    logic            hit_b;

    // a row written in the same cycle is forwarded to the read port
    assign hit_a = i_we && (i_waddr == i_raddr_a);
    assign hit_b = i_we && (i_waddr == i_raddr_b);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_q_a   <= mem[i_raddr_a];
            r_hit_a <= hit_a;
            r_fwd_a <= i_wdata;
        end
        if (i_re_b) begin
            r_q_b   <= mem[i_raddr_b];
            r_hit_b <= hit_b;
            r_fwd_b <= i_wdata;
        end
    end

    assign o_rdata_a = r_hit_a ? r_fwd_a : r_q_a;
    assign o_rdata_b = r_hit_b ? r_fwd_b : r_q_b;

endmodule

// ----- design/ising_metropolis_lattice.sv -----
`timescale 1ns / 1ps
// channel  dir  handshake                  payload
// in       in   i_in_valid / o_in_stall    i_action i_site i_spin_value i_random_fraction
// out      out  o_out_valid / i_out_stall  o_visited_site o_spin_after o_flipped
//                                          o_magnetization_total o_energy_total o_sweep_done
// cfg      in   psel penable pwrite pready paddr pwdata prdata
//
// items overlap in the pipeline; each needs three row reads (up, down, own row) on the
// two read ports of the lattice memory, the write-back shares a cycle with the next reads
// from input transfer to valid result an item passes the buffer, decode, read and execute stages
// after reset a clear pass writes all-up rows, input stalled meanwhile
// a stalled full output register freezes the pipeline; one more item waits at the input

module ising_metropolis_lattice #(
    parameter int ROWS = iml_pkg::ROWS_DEF,
    parameter int COLS = iml_pkg::COLS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic [iml_pkg::SITE_W-1:0]        i_site,
    input  logic                              i_spin_value,
    input  logic [iml_pkg::RND_W-1:0]         i_random_fraction,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [iml_pkg::SITE_W-1:0]        o_visited_site,
    output logic                              o_spin_after,
    output logic                              o_flipped,
    output logic signed [iml_pkg::MAG_W-1:0]  o_magnetization_total,
    output logic signed [iml_pkg::ENG_W-1:0]  o_energy_total,
    output logic                              o_sweep_done,

    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [iml_pkg::APB_AW-1:0]        paddr,
    input  logic [iml_pkg::APB_DW-1:0]        pwdata,
    output logic [iml_pkg::APB_DW-1:0]        prdata,
    output logic                              pready
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int SITES = ROWS * COLS;
    localparam int SW    = iml_pkg::SITE_W;
    localparam int TW    = iml_pkg::RND_W;
    localparam int MW    = iml_pkg::MAG_W;
    localparam int EW    = iml_pkg::ENG_W;
    localparam int RCW   = iml_pkg::RECIP_W;
    localparam int PRW   = SW + RCW;
    localparam int QW    = PRW - iml_pkg::RECIP_SHIFT;

    localparam logic [RCW-1:0]       RECIP     = RCW'((1 << iml_pkg::RECIP_SHIFT) / COLS);
    localparam logic signed [MW-1:0] MAG_RST   = MW'(SITES);
    localparam logic signed [EW-1:0] ENG_RST   = EW'(-2 * SITES);
    localparam logic signed [MW-1:0] MAG_STEP  = MW'(2);
    localparam logic [RW-1:0]        ROW_LAST  = RW'(ROWS - 1);
    localparam logic [CW-1:0]        COL_LAST  = CW'(COLS - 1);

    iml_pkg::t_thresholds thr;

    // control
    logic          r_clr;
    logic [RW-1:0] r_clr_row;
    logic          r_ph;
    logic          run;
    logic          adv;
    logic          in_xfer;
    logic          x_fire;

    // sweep position
    logic [RW-1:0] r_swp_row;
    logic [CW-1:0] r_swp_col;
    logic [SW-1:0] r_swp_site;
    logic          swp_last;

    // input buffer
    logic          r_i_v;
    logic          r_i_act;
    logic [SW-1:0] r_i_site;
    logic          r_i_spin;
    logic [TW-1:0] r_i_rnd;

    // decode stage
    logic           r_d_v;
    logic           r_d_act;
    logic [SW-1:0]  r_d_site;
    logic           r_d_spin;
    logic [TW-1:0]  r_d_rnd;
    logic [RW-1:0]  r_d_row;
    logic [CW-1:0]  r_d_col;
    logic           r_d_last;
    logic [PRW-1:0] r_prod;
    logic [QW-1:0]  q_est;
    logic [23:0]    qc;
    logic [23:0]    rem;
    logic           rem_ge;
    logic [QW-1:0]  dec_q;
    logic [23:0]    dec_c;
    logic           dec_inr;

    // read stage
    logic          r_m_v;
    logic          r_m_act;
    logic [SW-1:0] r_m_site;
    logic          r_m_spin;
    logic [TW-1:0] r_m_rnd;
    logic [RW-1:0] r_m_row;
    logic [CW-1:0] r_m_col;
    logic          r_m_inr;
    logic          r_m_last;
    logic [RW-1:0] m_up_row;
    logic [RW-1:0] m_dn_row;

    // execute stage
    logic            r_x_v;
    logic            r_x_act;
    logic [SW-1:0]   r_x_site;
    logic            r_x_spin;
    logic [TW-1:0]   r_x_rnd;
    logic [RW-1:0]   r_x_row;
    logic [CW-1:0]   r_x_col;
    logic            r_x_inr;
    logic            r_x_last;
    logic [COLS-1:0] r_up;

    logic [CW-1:0]   lcol;
    logic [CW-1:0]   rcol;
    logic            s_own;
    logic [2:0]      n_up;
    logic [2:0]      k_agree;
    logic            accept;
    logic            flip;
    logic signed [5:0]    de;
    logic signed [MW-1:0] n_mag;
    logic signed [EW-1:0] n_eng;
    logic signed [MW-1:0] r_mag;
    logic signed [EW-1:0] r_eng;

    // memory ports
    logic            ram_we;
    logic [RW-1:0]   ram_waddr;
    logic [COLS-1:0] ram_wdata;
    logic            ram_re_a;
    logic [RW-1:0]   ram_raddr_a;
    logic            ram_re_b;
    logic [COLS-1:0] ram_rd_a;
    logic [COLS-1:0] ram_rd_b;

    // output register
    logic          r_o_v;
    logic [SW-1:0] r_o_site;
    logic          r_o_spin;
    logic          r_o_flip;
    logic          r_o_done;

    iml_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_thr   (thr)
    );

    iml_lattice_ram #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_re_a    (ram_re_a),
        .i_raddr_a (ram_raddr_a),
        .i_re_b    (ram_re_b),
        .i_raddr_b (m_dn_row),
        .o_rdata_a (ram_rd_a),
        .o_rdata_b (ram_rd_b)
    );

    // slot timing: phase 0 reads up/down and writes back, phase 1 reads own row
    assign run     = !r_clr && !(r_o_v && i_out_stall);
    assign adv     = run && r_ph;
    assign x_fire  = run && !r_ph && r_x_v;
    assign o_in_stall = r_clr || r_i_v;
    assign in_xfer = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= 1'b1;
            r_clr_row <= '0;
            r_ph      <= 1'b0;
        end else begin
            if (r_clr) begin
                r_clr_row <= r_clr_row + RW'(1);
                if (r_clr_row == ROW_LAST) begin
                    r_clr <= 1'b0;
                end
            end
            if (run) begin
                r_ph <= !r_ph;
            end
        end
    end

    // sweep position
    assign swp_last = (r_swp_row == ROW_LAST) && (r_swp_col == COL_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swp_row  <= '0;
            r_swp_col  <= '0;
            r_swp_site <= '0;
        end else if (adv && r_i_v && (r_i_act == iml_pkg::ACT_UPDATE)) begin
            if (swp_last) begin
                r_swp_row  <= '0;
                r_swp_col  <= '0;
                r_swp_site <= '0;
            end else begin
                r_swp_site <= r_swp_site + SW'(1);
                if (r_swp_col == COL_LAST) begin
                    r_swp_col <= '0;
                    r_swp_row <= r_swp_row + RW'(1);
                end else begin
                    r_swp_col <= r_swp_col + CW'(1);
                end
            end
        end
    end

    // input buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v <= 1'b0;
        end else if (in_xfer) begin
            r_i_v <= 1'b1;
        end else if (adv) begin
            r_i_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_i_act  <= i_action;
            r_i_site <= i_site;
            r_i_spin <= i_spin_value;
            r_i_rnd  <= i_random_fraction;
        end
    end

    // decode stage: load sites split into row and column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (adv) begin
            r_d_v <= r_i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_d_act  <= r_i_act;
            r_d_site <= (r_i_act == iml_pkg::ACT_UPDATE) ? r_swp_site : r_i_site;
            r_d_spin <= r_i_spin;
            r_d_rnd  <= r_i_rnd;
            r_d_row  <= r_swp_row;
            r_d_col  <= r_swp_col;
            r_d_last <= swp_last;
        end
        if (run && !r_ph) begin
            r_prod <= PRW'(r_d_site) * PRW'(RECIP);
        end
    end

    assign q_est   = r_prod[PRW-1:iml_pkg::RECIP_SHIFT];
    assign qc      = 24'(q_est) * 24'(COLS);
    assign rem     = 24'(r_d_site) - qc;
    assign rem_ge  = rem >= 24'(COLS);
    assign dec_q   = q_est + QW'(rem_ge);
    assign dec_c   = rem_ge ? rem - 24'(COLS) : rem;
    assign dec_inr = 32'(r_d_site) < 32'(SITES);

    // read stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (adv) begin
            r_m_v <= r_d_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m_act  <= r_d_act;
            r_m_site <= r_d_site;
            r_m_spin <= r_d_spin;
            r_m_rnd  <= r_d_rnd;
            r_m_last <= r_d_last;
            if (r_d_act == iml_pkg::ACT_UPDATE) begin
                r_m_row <= r_d_row;
                r_m_col <= r_d_col;
                r_m_inr <= 1'b1;
            end else begin
                r_m_row <= RW'(dec_q);
                r_m_col <= CW'(dec_c);
                r_m_inr <= dec_inr;
            end
        end
        if (run && r_ph && r_m_v) begin
            r_up <= ram_rd_a;
        end
    end

    assign m_up_row    = (r_m_row == '0) ? ROW_LAST : r_m_row - RW'(1);
    assign m_dn_row    = (r_m_row == ROW_LAST) ? '0 : r_m_row + RW'(1);
    assign ram_re_a    = run && r_m_v;
    assign ram_re_b    = run && !r_ph && r_m_v;
    assign ram_raddr_a = r_ph ? r_m_row : m_up_row;

    // execute stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_v <= 1'b0;
        end else if (adv) begin
            r_x_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x_act  <= r_m_act;
            r_x_site <= r_m_site;
            r_x_spin <= r_m_spin;
            r_x_rnd  <= r_m_rnd;
            r_x_row  <= r_m_row;
            r_x_col  <= r_m_col;
            r_x_inr  <= r_m_inr;
            r_x_last <= r_m_last;
        end
    end

    assign lcol    = (r_x_col == '0) ? COL_LAST : r_x_col - CW'(1);
    assign rcol    = (r_x_col == COL_LAST) ? '0 : r_x_col + CW'(1);
    assign s_own   = ram_rd_a[r_x_col];
    assign n_up    = {2'b00, r_up[r_x_col]} + {2'b00, ram_rd_b[r_x_col]}
                   + {2'b00, ram_rd_a[lcol]} + {2'b00, ram_rd_a[rcol]};
    // neighbours that agree with the own spin
    assign k_agree = s_own ? n_up : 3'd4 - n_up;
    assign de      = $signed({1'b0, k_agree, 2'b00}) - 6'sd8;

    always_comb begin
        priority if (k_agree <= 3'd2) begin
            accept = 1'b1;
        end else if (k_agree == 3'd3) begin
            accept = r_x_rnd < thr.four;
        end else begin
            accept = r_x_rnd < thr.eight;
        end
    end

    assign flip  = (r_x_act == iml_pkg::ACT_UPDATE) ? accept
                                                    : (r_x_inr && (s_own != r_x_spin));
    assign n_mag = s_own ? r_mag - MAG_STEP : r_mag + MAG_STEP;
    assign n_eng = r_eng + {{(EW - 6){de[5]}}, de};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= MAG_RST;
            r_eng <= ENG_RST;
        end else if (x_fire && flip) begin
            r_mag <= n_mag;
            r_eng <= n_eng;
        end
    end

    // write port: clear pass, then flip write-back
    assign ram_we    = r_clr || (x_fire && flip);
    assign ram_waddr = r_clr ? r_clr_row : r_x_row;
    assign ram_wdata = r_clr ? '1 : (ram_rd_a ^ (COLS'(1) << r_x_col));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (x_fire) begin
            r_o_v <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (x_fire) begin
            r_o_site <= r_x_site;
            r_o_spin <= r_x_inr && (s_own ^ flip);
            r_o_flip <= flip;
            r_o_done <= (r_x_act == iml_pkg::ACT_UPDATE) && r_x_last;
        end
    end

    assign o_out_valid           = r_o_v;
    assign o_visited_site        = r_o_site;
    assign o_spin_after          = r_o_spin;
    assign o_flipped             = r_o_flip;
    assign o_magnetization_total = r_mag;
    assign o_energy_total        = r_eng;
    assign o_sweep_done          = r_o_done;

    a_mag_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag[0] == MAG_RST[0])
        else $error("magnetization total lost its parity");

    a_eng_mod4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eng[1:0] == ENG_RST[1:0])
        else $error("energy total changed by a step that is not a multiple of four");

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && !r_clr) |-> !r_ph)
        else $error("write-back outside the forwarding phase");

    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && i_out_stall) |-> !x_fire)
        else $error("result written over a stalled result");

    a_sweep_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_swp_col <= COL_LAST) && (r_swp_row <= ROW_LAST))
        else $error("sweep position left the lattice");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int ROWS = iml_pkg::ROWS_DEF;
    localparam int COLS = iml_pkg::COLS_DEF;
    localparam int SITES = ROWS * COLS;
    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD = 300;
    localparam int DRAIN_CYCLES = 16;

    typedef struct {
        logic                       action;
        logic [iml_pkg::SITE_W-1:0] site;
        logic                       spin_value;
        logic [iml_pkg::RND_W-1:0]  random_fraction;
    } t_spin_op;

    typedef struct {
        logic [iml_pkg::SITE_W-1:0]       visited_site;
        logic                             spin_after;
        logic                             flipped;
        logic signed [iml_pkg::MAG_W-1:0] magnetization_total;
        logic signed [iml_pkg::ENG_W-1:0] energy_total;
        logic                             sweep_done;
    } t_lattice_status;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                             i_in_valid = 1'b0;
    logic                             o_in_stall;
    logic                             i_action = iml_pkg::ACT_LOAD;
    logic [iml_pkg::SITE_W-1:0]       i_site = '0;
    logic                             i_spin_value = 1'b0;
    logic [iml_pkg::RND_W-1:0]        i_random_fraction = '0;

    logic                             o_out_valid;
    logic                             i_out_stall = 1'b0;
    logic [iml_pkg::SITE_W-1:0]       o_visited_site;
    logic                             o_spin_after;
    logic                             o_flipped;
    logic signed [iml_pkg::MAG_W-1:0] o_magnetization_total;
    logic signed [iml_pkg::ENG_W-1:0] o_energy_total;
    logic                             o_sweep_done;

    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [iml_pkg::APB_AW-1:0]       paddr = '0;
    logic [iml_pkg::APB_DW-1:0]       pwdata = '0;
    logic [iml_pkg::APB_DW-1:0]       prdata;
    logic                             pready;

    ising_metropolis_lattice #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_action             (i_action),
        .i_site               (i_site),
        .i_spin_value         (i_spin_value),
        .i_random_fraction    (i_random_fraction),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_visited_site       (o_visited_site),
        .o_spin_after         (o_spin_after),
        .o_flipped            (o_flipped),
        .o_magnetization_total(o_magnetization_total),
        .o_energy_total       (o_energy_total),
        .o_sweep_done         (o_sweep_done),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    // shadow copy of the lattice and its totals
    logic                      spins [SITES];
    int                        sweep_pos;
    int                        mag_sum;
    int                        bond_sum;
    logic [iml_pkg::RND_W-1:0] thr_four;
    logic [iml_pkg::RND_W-1:0] thr_eight;

    t_spin_op        queued_ops [$];
    t_lattice_status predicted_outputs [$];
    t_spin_op        op_on_bus;

    int ops_queued = 0;
    int ops_accepted = 0;
    int planned_sweep_pos = 0;
    int sender_gap_max = 4;
    int receiver_stall_max = 4;
    int send_gap = 0;
    int rx_stall_left = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int error_count = 0;
    int loads_sent = 0;
    int updates_sent = 0;
    int flips_seen = 0;

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int spin_sign(int idx);
        return spins[idx] ? 1 : -1;
    endfunction

    function automatic int neighbour_sum(int idx);
        int col;
        int up;
        int dn;
        int lf;
        int rt;
        col = idx % COLS;
        up = (idx + SITES - COLS) % SITES;
        dn = (idx + COLS) % SITES;
        lf = (col == 0) ? idx + COLS - 1 : idx - 1;
        rt = (col == COLS - 1) ? idx + 1 - COLS : idx + 1;
        return spin_sign(up) + spin_sign(dn) + spin_sign(lf) + spin_sign(rt);
    endfunction

    function automatic void flip_spin(int idx);
        int s;
        s = spin_sign(idx);
        bond_sum += 2 * s * neighbour_sum(idx);
        mag_sum -= 2 * s;
        spins[idx] = ~spins[idx];
    endfunction

    function automatic t_lattice_status metropolis_step(t_spin_op op);
        t_lattice_status r;
        int idx;
        int delta_e;
        logic accept;
        r = '{default: '0};
        if (op.action == iml_pkg::ACT_LOAD) begin
            idx = int'(op.site);
            r.visited_site = op.site;
            if (idx < SITES) begin
                if (spins[idx] != op.spin_value) begin
                    flip_spin(idx);
                    r.flipped = 1'b1;
                end
                r.spin_after = spins[idx];
            end
        end else begin
            idx = sweep_pos;
            delta_e = 2 * spin_sign(idx) * neighbour_sum(idx);
            if (delta_e <= 0) begin
                accept = 1'b1;
            end else if (delta_e == 4) begin
                accept = op.random_fraction < thr_four;
            end else begin
                accept = op.random_fraction < thr_eight;
            end
            if (accept) begin
                flip_spin(idx);
                r.flipped = 1'b1;
            end
            r.visited_site = idx[iml_pkg::SITE_W-1:0];
            r.spin_after = spins[idx];
            if (idx == SITES - 1) begin
                r.sweep_done = 1'b1;
                sweep_pos = 0;
            end else begin
                sweep_pos = idx + 1;
            end
        end
        r.magnetization_total = mag_sum[iml_pkg::MAG_W-1:0];
        r.energy_total = bond_sum[iml_pkg::ENG_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    // input channel
    always @(posedge i_clk) begin
        logic offer;
        offer = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predicted_outputs.push_back(metropolis_step(op_on_bus));
                ops_accepted++;
                if (op_on_bus.action == iml_pkg::ACT_LOAD) begin
                    loads_sent++;
                end else begin
                    updates_sent++;
                end
                offer = 1'b0;
                send_gap = $urandom_range(0, sender_gap_max);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (queued_ops.size() > 0) begin
                    op_on_bus = queued_ops.pop_front();
                    i_action <= op_on_bus.action;
                    i_site <= op_on_bus.site;
                    i_spin_value <= op_on_bus.spin_value;
                    i_random_fraction <= op_on_bus.random_fraction;
                    offer = 1'b1;
                end
            end
        end
        i_in_valid <= offer;
    end

    // output channel
    always @(posedge i_clk) begin
        t_lattice_status want;
        logic hold;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (o_flipped) flips_seen++;
                if (predicted_outputs.size() == 0) begin
                    $error("result transfer with no prediction pending, site %0d",
                           o_visited_site);
                    error_count++;
                end else begin
                    want = predicted_outputs.pop_front();
                    check_field("visited_site", want.visited_site, o_visited_site);
                    check_field("spin_after", want.spin_after, o_spin_after);
                    check_field("flipped", want.flipped, o_flipped);
                    check_field("magnetization_total", want.magnetization_total,
                                o_magnetization_total);
                    check_field("energy_total", want.energy_total, o_energy_total);
                    check_field("sweep_done", want.sweep_done, o_sweep_done);
                end
                rx_stall_left = $urandom_range(0, receiver_stall_max);
            end
            if (holds_served != hold_requests) begin
                holds_served = hold_requests;
                rx_stall_left = LONG_HOLD;
            end
        end
        hold = 1'b0;
        if (rx_stall_left > 0) begin
            hold = 1'b1;
            rx_stall_left--;
        end
        i_out_stall <= hold;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $error("no transfer for %0d cycles", QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic apb_transfer(input logic write, input logic [iml_pkg::APB_AW-1:0] addr,
                                input logic [iml_pkg::APB_DW-1:0] wdata,
                                output logic [iml_pkg::APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [iml_pkg::RND_W-1:0] four,
                                  input logic [iml_pkg::RND_W-1:0] eight);
        logic [iml_pkg::APB_DW-1:0] readback;
        apb_transfer(1'b1, {iml_pkg::REG_THR_FOUR, 2'b00}, four, readback);
        apb_transfer(1'b1, {iml_pkg::REG_THR_EIGHT, 2'b00}, eight, readback);
        thr_four = four;
        thr_eight = eight;
        apb_transfer(1'b0, {iml_pkg::REG_THR_FOUR, 2'b00}, '0, readback);
        if (readback !== four) begin
            $error("accept_threshold_four readback: expected %0d, actual %0d", four, readback);
            error_count++;
        end
        apb_transfer(1'b0, {iml_pkg::REG_THR_EIGHT, 2'b00}, '0, readback);
        if (readback !== eight) begin
            $error("accept_threshold_eight readback: expected %0d, actual %0d",
                   eight, readback);
            error_count++;
        end
    endtask

    task automatic queue_op(input logic act, input logic [iml_pkg::SITE_W-1:0] site,
                            input logic spin, input logic [iml_pkg::RND_W-1:0] rnd);
        t_spin_op op;
        op.action = act;
        op.site = site;
        op.spin_value = spin;
        op.random_fraction = rnd;
        queued_ops.push_back(op);
        ops_queued++;
        if (act == iml_pkg::ACT_UPDATE) planned_sweep_pos = (planned_sweep_pos + 1) % SITES;
    endtask

    task automatic queue_random_ops(input int count);
        logic [iml_pkg::SITE_W-1:0] site;
        logic [iml_pkg::RND_W-1:0]  rnd;
        int                         offset;
        repeat (count) begin
            // loads mostly land near the sweep front to vary the neighborhoods it meets
            if ($urandom_range(0, 9) < 7) begin
                offset = $urandom_range(0, 140) - 70;
                site = iml_pkg::SITE_W'((planned_sweep_pos + SITES + offset) % SITES);
            end else begin
                site = iml_pkg::SITE_W'($urandom);
            end
            case ($urandom_range(0, 9))
                0: rnd = '0;
                1: rnd = '1;
                2: rnd = thr_four - iml_pkg::RND_W'($urandom_range(0, 1));
                3: rnd = thr_eight - iml_pkg::RND_W'($urandom_range(0, 1));
                default: rnd = $urandom;
            endcase
            queue_op(($urandom_range(0, 9) < 6) ? iml_pkg::ACT_UPDATE : iml_pkg::ACT_LOAD,
                     site, 1'($urandom), rnd);
        end
    endtask

    task automatic wait_until_drained();
        while (ops_accepted != ops_queued || predicted_outputs.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        logic [iml_pkg::RND_W-1:0] mid_four;
        for (int i = 0; i < SITES; i++) spins[i] = 1'b1;
        sweep_pos = 0;
        mag_sum = SITES;
        bond_sum = -2 * SITES;
        thr_four = iml_pkg::THR_FOUR_RST;
        thr_eight = iml_pkg::THR_EIGHT_RST;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset thresholds, hand-picked transfers
        queue_op(iml_pkg::ACT_UPDATE, 12'd0, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_UPDATE, 12'hFFF, 1'b1, 32'hFFFF_FFFF);
        queue_op(iml_pkg::ACT_LOAD, 12'd4095, 1'b0, 32'hFFFF_FFFF);
        queue_op(iml_pkg::ACT_LOAD, 12'd4095, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd4095, 1'b1, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd1, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd3, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd66, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd4034, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_UPDATE, 12'd0, 1'b0, 32'hFFFF_FFFF);
        queue_op(iml_pkg::ACT_UPDATE, 12'd0, 1'b1, iml_pkg::THR_FOUR_RST - 32'd1);
        queue_op(iml_pkg::ACT_UPDATE, 12'd0, 1'b0, iml_pkg::THR_FOUR_RST);
        queue_op(iml_pkg::ACT_LOAD, 12'd63, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd64, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd4032, 1'b0, 32'd0);
        queue_op(iml_pkg::ACT_UPDATE, 12'd0, 1'b0, iml_pkg::THR_EIGHT_RST - 32'd1);
        queue_op(iml_pkg::ACT_UPDATE, 12'd0, 1'b0, iml_pkg::THR_EIGHT_RST);
        queue_op(iml_pkg::ACT_LOAD, 12'd0, 1'b1, 32'd0);
        queue_op(iml_pkg::ACT_LOAD, 12'd2048, 1'b0, 32'h8000_0000);
        queue_op(iml_pkg::ACT_UPDATE, 12'hAAA, 1'b1, 32'h5555_5555);
        wait_until_drained();

        set_thresholds('0, '0);
        queue_random_ops(120);
        wait_until_drained();

        set_thresholds('1, '1);
        queue_random_ops(120);
        wait_until_drained();

        set_thresholds('1, '0);
        queue_random_ops(60);
        wait_until_drained();

        mid_four = $urandom;
        set_thresholds(mid_four, iml_pkg::RND_W'($urandom_range(0, 32'hFFFF_FFFF)) & mid_four);
        queue_random_ops(150);
        wait_until_drained();

        // back-to-back with no stalls on either side
        sender_gap_max = 0;
        receiver_stall_max = 0;
        queue_random_ops(150);
        wait_until_drained();

        // output held off while the input keeps offering
        hold_requests++;
        queue_random_ops(150);
        wait_until_drained();

        sender_gap_max = 4;
        receiver_stall_max = 4;
        set_thresholds(iml_pkg::THR_FOUR_RST, iml_pkg::THR_EIGHT_RST);
        queue_random_ops(150);
        wait_until_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d loads and %0d updates with %0d flips",
                 loads_sent, updates_sent, flips_seen);
        $display("thresholds exercised at zero, full scale, mixed and reset values");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/iml_pkg.sv
design/iml_cfg_regs.sv
design/iml_lattice_ram.sv
design/ising_metropolis_lattice.sv
sim/testbench.sv
